[rtl/dcs_pkg.sv]
`timescale 1ns / 1ps

package dcs_pkg;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_PUSH_FWD   = 3'd1,
		OP_PUSH_LEFT  = 3'd2,
		OP_PUSH_RIGHT = 3'd3,
		OP_START      = 3'd4,
		OP_CANCEL     = 3'd5,
		OP_UNDO       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		CMD_FWD   = 2'd0,
		CMD_LEFT  = 2'd1,
		CMD_RIGHT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} seq_ctrl_t;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned DIST_W   = 9;
	localparam int unsigned TICKS_W  = 16;
	localparam int unsigned QCOUNT_W = 7;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE     = 1'd1;

	localparam logic [DIST_W-1:0]  OBSTACLE_RST = 9'd30;
	localparam logic [TICKS_W-1:0] MOVE_RST     = 16'd2000;
	localparam logic [TICKS_W-1:0] TICKS_MAX    = 16'hFFFF;

endpackage

[rtl/drive_command_sequencer_unit.sv]
`timescale 1ns / 1ps

// Drive command sequencer: keeps a list of forward/left/right commands and runs it on
// ticks that each carry a distance sample, stopping both motors while the path is blocked.
// Item channel: op and distance_cm with item_valid/item_stall; a beat moves when valid
// is high and stall is low. Every item yields exactly one result beat on the result
// channel (result_valid/result_stall) giving motor levels and list status after the item.
// Configuration: cfg_valid/cfg_ready write port, index 0 obstacle threshold, index 1
// command length in ticks; cfg_ready is always high. Write only while the block is idle.
// Timing: an item is captured while the command store is read at the current position,
// and the state update lands in the next cycle unless the previous result is still stalled;
// the result is registered by the update, and no new item is taken until that update has
// landed. The registered store read is why capture and update are split this way.
// A result register sits between the two channels, so one new item is taken while a
// result waits; if result_stall holds, that item parks until the result leaves and the
// item channel stalls meanwhile.
// Reset: list empty, motors off, not running, threshold 30 cm, command length 2000 ticks.
// The command store itself is not cleared; only entries below the list count are used.
module drive_command_sequencer_unit #(
	parameter int unsigned LIST_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [dcs_pkg::OP_W-1:0]            op,
	input  logic [dcs_pkg::DIST_W-1:0]          distance_cm,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                left_on,
	output logic                                right_on,
	output logic                                running,
	output logic                                blocked_wait,
	output logic [dcs_pkg::QCOUNT_W-1:0]        queued_count,
	output logic                                push_dropped,
	output logic                                list_done,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	dcs_pkg::seq_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	dcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctrl         (ctrl)
	);

	dcs_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.op           (op),
		.distance_cm  (distance_cm),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.left_on      (left_on),
		.right_on     (right_on),
		.running      (running),
		.blocked_wait (blocked_wait),
		.queued_count (queued_count),
		.push_dropped (push_dropped),
		.list_done    (list_done)
	);

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> result_valid)
		else $error("result not presented after an update");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && list_done |-> !running && queued_count == '0)
		else $error("list done while still running or list not empty");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && push_dropped |-> queued_count == dcs_pkg::QCOUNT_W'(LIST_DEPTH))
		else $error("push dropped while list not full");

	a_wait_motors_off: assert property (@(posedge clk) disable iff (!arst_n)
		blocked_wait |-> !left_on && !right_on)
		else $error("motor driven while waiting on obstacle");
`endif

endmodule

[rtl/dcs_ctrl.sv]
`timescale 1ns / 1ps

module dcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	output dcs_pkg::seq_ctrl_t  ctrl
);

	dcs_pkg::state_t state_q, state_n;
	logic            out_valid_q;
	logic            slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dcs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.commit)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	// The update may only land once the previous result has left or is leaving.
	assign slot_free = !out_valid_q || !result_stall;

	always_comb begin
		state_n      = state_q;
		item_stall   = 1'b1;
		ctrl.capture = 1'b0;
		ctrl.commit  = 1'b0;
		unique case (state_q)
			dcs_pkg::ST_IDLE: begin
				item_stall   = 1'b0;
				ctrl.capture = item_valid;
				if (item_valid)
					state_n = dcs_pkg::ST_EXEC;
			end
			dcs_pkg::ST_EXEC: begin
				ctrl.commit = slot_free;
				if (slot_free)
					state_n = dcs_pkg::ST_IDLE;
			end
			default: state_n = dcs_pkg::ST_IDLE;
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

[rtl/dcs_dpath.sv]
`timescale 1ns / 1ps

module dcs_dpath #(
	parameter int unsigned LIST_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dcs_pkg::seq_ctrl_t                  ctrl,
	input  logic [dcs_pkg::OP_W-1:0]            op,
	input  logic [dcs_pkg::DIST_W-1:0]          distance_cm,
	input  logic                                cfg_we,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dcs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                left_on,
	output logic                                right_on,
	output logic                                running,
	output logic                                blocked_wait,
	output logic [dcs_pkg::QCOUNT_W-1:0]        queued_count,
	output logic                                push_dropped,
	output logic                                list_done
);

	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic [1:0] store_mem [LIST_DEPTH];

	logic [dcs_pkg::DIST_W-1:0]  obstacle_q;
	logic [dcs_pkg::TICKS_W-1:0] move_ticks_q;

	dcs_pkg::op_t                op_q;
	logic [dcs_pkg::DIST_W-1:0]  dist_q;
	logic [1:0]                  rd_code_q;

	logic [CW-1:0]               count_q, count_n;
	logic [CW-1:0]               index_q, index_n;
	logic                        run_q, run_n;
	logic                        move_q, move_n;
	logic                        wait_q, wait_n;
	logic [dcs_pkg::TICKS_W-1:0] elapsed_q, elapsed_n;
	logic                        left_q, left_n;
	logic                        right_q, right_n;
	logic                        dropped_q, dropped_n;
	logic                        done_q, done_n;
	logic                        mem_we;
	logic                        blocked;
	logic                        not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q   <= dcs_pkg::OBSTACLE_RST;
			move_ticks_q <= dcs_pkg::MOVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dcs_pkg::CFG_OBSTACLE: obstacle_q   <= cfg_data[dcs_pkg::DIST_W-1:0];
				dcs_pkg::CFG_MOVE:     move_ticks_q <= cfg_data[dcs_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// Item capture; the store is read at the current index for a possible tick.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			op_q      <= dcs_pkg::op_t'(op);
			dist_q    <= distance_cm;
			rd_code_q <= store_mem[index_q[AW-1:0]];
		end
		if (mem_we)
			store_mem[count_q[AW-1:0]] <= 2'(op_q) - 2'd1;
	end

	assign not_full = count_q < CW'(LIST_DEPTH);
	assign blocked  = dist_q <= obstacle_q;
	assign mem_we   = ctrl.commit && not_full &&
		(op_q == dcs_pkg::OP_PUSH_FWD || op_q == dcs_pkg::OP_PUSH_LEFT ||
		 op_q == dcs_pkg::OP_PUSH_RIGHT);

	always_comb begin
		count_n   = count_q;
		index_n   = index_q;
		run_n     = run_q;
		move_n    = move_q;
		wait_n    = wait_q;
		elapsed_n = elapsed_q;
		left_n    = left_q;
		right_n   = right_q;
		dropped_n = 1'b0;
		done_n    = 1'b0;
		case (op_q)
			dcs_pkg::OP_TICK: begin
				if (elapsed_q != dcs_pkg::TICKS_MAX)
					elapsed_n = elapsed_q + 1'b1;
				if (run_q) begin
					if (index_q >= count_q) begin
						run_n   = 1'b0;
						index_n = '0;
						count_n = '0;
						done_n  = 1'b1;
					end else if (blocked && !wait_q) begin
						left_n  = 1'b0;
						right_n = 1'b0;
						wait_n  = 1'b1;
					end else begin
						// A cleared path restarts the current command from scratch.
						if (!blocked && wait_q) begin
							wait_n = 1'b0;
							move_n = 1'b0;
						end
						if (!move_n && !wait_n) begin
							elapsed_n = '0;
							move_n    = 1'b1;
							case (dcs_pkg::cmd_code_t'(rd_code_q))
								dcs_pkg::CMD_FWD: begin
									left_n  = 1'b1;
									right_n = 1'b1;
								end
								dcs_pkg::CMD_LEFT:  right_n = 1'b1;
								dcs_pkg::CMD_RIGHT: left_n  = 1'b1;
								default: ;
							endcase
						end
						// The timer keeps running while paused and may end a command then.
						if (move_n && elapsed_n >= move_ticks_q) begin
							left_n  = 1'b0;
							right_n = 1'b0;
							move_n  = 1'b0;
							index_n = index_q + 1'b1;
						end
					end
				end
			end
			dcs_pkg::OP_PUSH_FWD, dcs_pkg::OP_PUSH_LEFT, dcs_pkg::OP_PUSH_RIGHT: begin
				if (not_full)
					count_n = count_q + 1'b1;
				else
					dropped_n = 1'b1;
			end
			dcs_pkg::OP_START: begin
				if (count_q != '0) begin
					run_n   = 1'b1;
					index_n = '0;
					move_n  = 1'b0;
					wait_n  = 1'b0;
				end
			end
			dcs_pkg::OP_CANCEL: begin
				run_n   = 1'b0;
				move_n  = 1'b0;
				count_n = '0;
				left_n  = 1'b0;
				right_n = 1'b0;
			end
			dcs_pkg::OP_UNDO: begin
				if (count_q != '0)
					count_n = count_q - 1'b1;
			end
			default: count_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			index_q   <= '0;
			run_q     <= 1'b0;
			move_q    <= 1'b0;
			wait_q    <= 1'b0;
			elapsed_q <= '0;
			left_q    <= 1'b0;
			right_q   <= 1'b0;
			dropped_q <= 1'b0;
			done_q    <= 1'b0;
		end else if (ctrl.commit) begin
			count_q   <= count_n;
			index_q   <= index_n;
			run_q     <= run_n;
			move_q    <= move_n;
			wait_q    <= wait_n;
			elapsed_q <= elapsed_n;
			left_q    <= left_n;
			right_q   <= right_n;
			dropped_q <= dropped_n;
			done_q    <= done_n;
		end
	end

	assign left_on      = left_q;
	assign right_on     = right_q;
	assign running      = run_q;
	assign blocked_wait = wait_q;
	assign queued_count = dcs_pkg::QCOUNT_W'(count_q);
	assign push_dropped = dropped_q;
	assign list_done    = done_q;

endmodule
